// File: hdl/assert_macros.svh
// Assertion helpers for the checker file lfsa_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/lfsa_pkg.sv
`timescale 1ns / 1ps

package lfsa_pkg;

	localparam int SERVERS_DEF  = 16;
	localparam int FIN_W        = 32;
	localparam int TIME_W       = 31;
	localparam int SRV_NUM_W    = 5;
	localparam logic [SRV_NUM_W-1:0] SERVERS_IN_USE_RST = 5'd16;

	typedef struct packed {
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] job_duration;
	} in_word_t;

	typedef struct packed {
		logic [SRV_NUM_W-1:0] assigned_server;
		logic [FIN_W-1:0]     finish_time;
		logic [FIN_W-1:0]     latest_finish;
		logic [SRV_NUM_W-1:0] latest_server;
	} out_word_t;

	// Compare flags from the shared unit.
	typedef struct packed {
		logic a_le_b;
		logic a_lt_c;
		logic a_eq_c;
	} cmp_t;

endpackage

// File: hdl/lowest_free_server_assigner.sv
`timescale 1ns / 1ps
// Flow: an accepted job passes the scan, calc and done states, done waiting while the output stalls,
// and no new job is taken until it returns to idle; one RAM read port scans finish times one per cycle.
// Reset: after arst_n releases, a clearing pass writes zero to all SERVERS entries
// with in_stall high; servers_in_use resets to 16, record to zero.

module lowest_free_server_assigner #(
	parameter int SERVERS = lfsa_pkg::SERVERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  lfsa_pkg::in_word_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output lfsa_pkg::out_word_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lfsa_pkg::SRV_NUM_W-1:0]     cfg_data
);

	localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
	localparam int CNT_W = $clog2(SERVERS + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                          state_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [CNT_W-1:0]                    n_q;
	logic                                found_q;
	logic                                out_vld_q;
	logic [lfsa_pkg::SRV_NUM_W-1:0]      srv_use_q;
	logic [lfsa_pkg::FIN_W-1:0]          rec_fin_q;
	logic [CNT_W-1:0]                    rec_srv_q;

	logic [lfsa_pkg::TIME_W-1:0]         arr_q;
	logic [lfsa_pkg::TIME_W-1:0]         dur_q;
	logic [IDX_W-1:0]                    pick_idx_q;
	logic [lfsa_pkg::FIN_W-1:0]          pick_fin_q;
	logic [IDX_W-1:0]                    min_idx_q;
	logic [lfsa_pkg::FIN_W-1:0]          min_fin_q;
	logic [lfsa_pkg::FIN_W-1:0]          fin_q;
	logic [IDX_W-1:0]                    sel_q;
	lfsa_pkg::out_word_t                 out_q;

	logic [CNT_W-1:0]                    act_n;
	logic [IDX_W-1:0]                    idx;
	logic                                ram_we;
	logic [IDX_W-1:0]                    ram_addr;
	logic [lfsa_pkg::FIN_W-1:0]          ram_wdata;
	logic [lfsa_pkg::FIN_W-1:0]          ram_rdata;
	logic [lfsa_pkg::FIN_W-1:0]          alu_a;
	logic [lfsa_pkg::FIN_W-1:0]          alu_c;
	logic [lfsa_pkg::FIN_W-1:0]          alu_sum;
	lfsa_pkg::cmp_t                      cmp;
	logic [CNT_W-1:0]                    num;
	logic                                rec_upd;
	logic                                out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign out_free  = !out_vld_q || !out_stall;

	// Clamp the configured count into 1..SERVERS.
	always_comb begin
		if (srv_use_q == '0) begin
			act_n = CNT_W'(1);
		end else if (32'(srv_use_q) > 32'(SERVERS)) begin
			act_n = CNT_W'(SERVERS);
		end else begin
			act_n = CNT_W'(srv_use_q);
		end
	end

	// Read data is registered, so the entry read back is the previous address, cnt_q - 1.
	assign idx = IDX_W'(cnt_q - CNT_W'(1));

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_DONE) && out_free);
	assign ram_addr  = (state_q == ST_DONE) ? sel_q : cnt_q[IDX_W-1:0];
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : fin_q;

	always_comb begin
		unique case (state_q)
			ST_SCAN: begin
				alu_a = ram_rdata;
				alu_c = min_fin_q;
			end
			ST_CALC: begin
				alu_a = found_q ? pick_fin_q : min_fin_q;
				alu_c = rec_fin_q;
			end
			default: begin
				alu_a = fin_q;
				alu_c = rec_fin_q;
			end
		endcase
	end

	assign num     = CNT_W'(sel_q) + CNT_W'(1);
	assign rec_upd = !cmp.a_lt_c && (!cmp.a_eq_c || (num > rec_srv_q));

	lfsa_ram #(
		.WIDTH(lfsa_pkg::FIN_W),
		.DEPTH(SERVERS),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	lfsa_alu u_alu (
		.a(alu_a),
		.b(arr_q),
		.c(alu_c),
		.d(dur_q),
		.cmp(cmp),
		.sum_sat(alu_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			n_q       <= '0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
			srv_use_q <= lfsa_pkg::SERVERS_IN_USE_RST;
			rec_fin_q <= '0;
			rec_srv_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				srv_use_q <= cfg_data;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CNT_W'(SERVERS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						n_q     <= act_n;
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if ((cnt_q != '0) && !found_q && cmp.a_le_b) begin
						found_q <= 1'b1;
					end
					if (cnt_q == n_q) begin
						state_q <= ST_CALC;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_CALC: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						if (rec_upd) begin
							rec_fin_q <= fin_q;
							rec_srv_q <= num;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			arr_q <= in_data.arrival_time;
			dur_q <= in_data.job_duration;
		end
		if ((state_q == ST_SCAN) && (cnt_q != '0)) begin
			// First server already free wins; otherwise track earliest finish.
			if (!found_q && cmp.a_le_b) begin
				pick_idx_q <= idx;
				pick_fin_q <= ram_rdata;
			end
			if ((idx == '0) || cmp.a_lt_c) begin
				min_idx_q <= idx;
				min_fin_q <= ram_rdata;
			end
		end
		if (state_q == ST_CALC) begin
			fin_q <= alu_sum;
			sel_q <= found_q ? pick_idx_q : min_idx_q;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q.assigned_server <= lfsa_pkg::SRV_NUM_W'(num);
			out_q.finish_time     <= fin_q;
			out_q.latest_finish   <= rec_upd ? fin_q : rec_fin_q;
			out_q.latest_server   <= lfsa_pkg::SRV_NUM_W'(rec_upd ? num : rec_srv_q);
		end
	end

endmodule

// File: hdl/lfsa_ram.sv
`timescale 1ns / 1ps

module lfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: hdl/lfsa_alu.sv
`timescale 1ns / 1ps

module lfsa_alu (
	input  logic [lfsa_pkg::FIN_W-1:0]  a,
	input  logic [lfsa_pkg::TIME_W-1:0] b,
	input  logic [lfsa_pkg::FIN_W-1:0]  c,
	input  logic [lfsa_pkg::TIME_W-1:0] d,
	output lfsa_pkg::cmp_t              cmp,
	output logic [lfsa_pkg::FIN_W-1:0]  sum_sat
);

	logic [lfsa_pkg::FIN_W-1:0] b_ext;
	logic [lfsa_pkg::FIN_W-1:0] base;
	logic [lfsa_pkg::FIN_W:0]   sum;

	assign b_ext      = {1'b0, b};
	assign cmp.a_le_b = (a <= b_ext);
	assign cmp.a_lt_c = (a < c);
	assign cmp.a_eq_c = (a == c);

	// Later of the two start points plus duration, held at all ones on carry.
	assign base    = cmp.a_le_b ? b_ext : a;
	assign sum     = {1'b0, base} + {2'b00, d};
	assign sum_sat = sum[lfsa_pkg::FIN_W] ? {lfsa_pkg::FIN_W{1'b1}} : sum[lfsa_pkg::FIN_W-1:0];

endmodule

// File: hdl/lfsa_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfsa_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input lfsa_pkg::out_word_t            out_data,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	// Accepting a job makes the block busy.
	`AST_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A new result only appears after a busy cycle.
	`AST_IMPL(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

	// Configuration writes are never held off.
	`AST_IMPL(a_cfg_always_ready, clk, arst_n, cfg_valid, cfg_ready)

	// Hold a stalled result word.
	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind lowest_free_server_assigner lfsa_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

// File: dv/tb_lowest_free_server_assigner.sv
`timescale 1ns / 1ps

module tb_lowest_free_server_assigner;

	localparam int SERVERS = lfsa_pkg::SERVERS_DEF;
	localparam logic [lfsa_pkg::TIME_W-1:0] TIME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lfsa_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lfsa_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lfsa_pkg::SRV_NUM_W-1:0] cfg_data = '0;

	lowest_free_server_assigner #(.SERVERS(SERVERS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// schedule model: finish time per server plus the latest-finish record
	logic [lfsa_pkg::FIN_W-1:0] srv_finish [SERVERS];
	logic [lfsa_pkg::FIN_W-1:0] top_finish = '0;
	int unsigned top_server = 0;
	logic [lfsa_pkg::SRV_NUM_W-1:0] srv_count = lfsa_pkg::SERVERS_IN_USE_RST;

	lfsa_pkg::in_word_t job_q[$];
	lfsa_pkg::out_word_t assign_q[$];
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int unsigned hold_left = 0;
	longint timeline = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_miss(string what);
		if (mismatches < 100)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic lfsa_pkg::out_word_t place_job(lfsa_pkg::in_word_t job);
		lfsa_pkg::out_word_t res;
		int cnt;
		int pick;
		bit found;
		logic [lfsa_pkg::FIN_W-1:0] arr;
		logic [lfsa_pkg::FIN_W-1:0] base;
		logic [lfsa_pkg::FIN_W-1:0] fin;
		logic [lfsa_pkg::FIN_W:0] sum;
		cnt = int'(srv_count);
		if (cnt < 1) cnt = 1;
		if (cnt > SERVERS) cnt = SERVERS;
		arr = {1'b0, job.arrival_time};
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < cnt; i++) begin
			if (!found && srv_finish[i] <= arr) begin
				pick = i;
				found = 1'b1;
			end
		end
		// nobody free: earliest finish, lower number on ties
		if (!found) begin
			for (int i = 1; i < cnt; i++)
				if (srv_finish[i] < srv_finish[pick]) pick = i;
		end
		base = (srv_finish[pick] > arr) ? srv_finish[pick] : arr;
		sum = {1'b0, base} + {2'b00, job.job_duration};
		fin = sum[lfsa_pkg::FIN_W] ? '1 : sum[lfsa_pkg::FIN_W-1:0];
		srv_finish[pick] = fin;
		if (fin > top_finish || (fin == top_finish && pick + 1 > top_server)) begin
			top_finish = fin;
			top_server = pick + 1;
		end
		res.assigned_server = lfsa_pkg::SRV_NUM_W'(pick + 1);
		res.finish_time = fin;
		res.latest_finish = top_finish;
		res.latest_server = lfsa_pkg::SRV_NUM_W'(top_server);
		return res;
	endfunction

	// driver: hold the word while stalled, else load the next job or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				assign_q.push_back(place_job(in_data));
			if (!in_valid || !in_stall) begin
				if (job_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= job_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		lfsa_pkg::out_word_t want;
		string diff;
		if (arst_n && out_valid && !out_stall) begin
			if (assign_q.size() == 0) begin
				report_miss($sformatf("unexpected word, server %0d finish %0d",
					out_data.assigned_server, out_data.finish_time));
			end else begin
				want = assign_q.pop_front();
				diff = "";
				if (out_data.assigned_server !== want.assigned_server)
					diff = {diff, $sformatf(" server %0d/%0d",
						out_data.assigned_server, want.assigned_server)};
				if (out_data.finish_time !== want.finish_time)
					diff = {diff, $sformatf(" finish %0d/%0d",
						out_data.finish_time, want.finish_time)};
				if (out_data.latest_finish !== want.latest_finish)
					diff = {diff, $sformatf(" latest %0d/%0d",
						out_data.latest_finish, want.latest_finish)};
				if (out_data.latest_server !== want.latest_server)
					diff = {diff, $sformatf(" latest server %0d/%0d",
						out_data.latest_server, want.latest_server)};
				if (diff != "")
					report_miss({"got/want", diff});
			end
		end
	end

	function automatic logic [lfsa_pkg::TIME_W-1:0] clamp_time(longint t);
		if (t < 0) return '0;
		if (t > longint'(TIME_MAX)) return TIME_MAX;
		return lfsa_pkg::TIME_W'(t);
	endfunction

	task automatic add_job(logic [lfsa_pkg::TIME_W-1:0] arr,
		logic [lfsa_pkg::TIME_W-1:0] dur);
		lfsa_pkg::in_word_t job;
		job.arrival_time = arr;
		job.job_duration = dur;
		job_q.push_back(job);
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (job_q.size() != 0 || in_valid || assign_q.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_servers(logic [lfsa_pkg::SRV_NUM_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		srv_count = value;
	endtask

	// drain, reprogram the server count, then pick the idle profile
	task automatic begin_phase(logic [lfsa_pkg::SRV_NUM_W-1:0] count, int mode);
		wait_idle();
		write_servers(count);
		@(negedge clk);
		send_idle_pct = (mode == 1) ? 75 : (mode == 3) ? 24 : 0;
		recv_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 24 : 0;
	endtask

	// mostly ordered arrivals, equal arrivals longest first; some jobs out of order
	task automatic queue_jobs(int count, int unsigned dur_max, int unsigned gap_max);
		int unsigned dur;
		int unsigned prev_dur;
		int unsigned step;
		prev_dur = dur_max;
		repeat (count) begin
			if ($urandom_range(99) < 8) begin
				add_job(clamp_time(timeline - $urandom_range(0, gap_max * 4)),
					lfsa_pkg::TIME_W'($urandom_range(0, dur_max * 4)));
			end else begin
				step = $urandom_range(0, gap_max);
				if ($urandom_range(49) == 0)
					step += $urandom_range(0, 1 << 20);
				timeline += step;
				dur = (step == 0) ? $urandom_range(0, prev_dur) : $urandom_range(0, dur_max);
				prev_dur = dur;
				add_job(clamp_time(timeline), lfsa_pkg::TIME_W'(dur));
			end
		end
	endtask

	initial begin
		int unsigned cnt_eff;
		int unsigned dur_max;
		logic [lfsa_pkg::SRV_NUM_W-1:0] count;
		for (int i = 0; i < SERVERS; i++)
			srv_finish[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single server, then a count of zero that acts as one
		begin_phase(5'd1, 0);
		add_job(31'd0, 31'd7);
		add_job(31'd0, 31'd0);
		add_job(31'd2, 31'd1);
		begin_phase(5'd0, 2);
		add_job(31'd9, 31'd3);
		add_job(31'd9, 31'd1);
		// count above the server total, record ties, one arrival out of order
		begin_phase(5'd31, 1);
		add_job(31'd20, 31'd5);
		add_job(31'd20, 31'd5);
		add_job(31'd20, 31'd4);
		add_job(31'd21, 31'd0);
		add_job(31'd25, 31'd10);
		add_job(31'd19, 31'd1);
		// shrink the pool; the upper servers keep their finish times
		begin_phase(5'd2, 3);
		add_job(31'd22, 31'd3);
		add_job(31'd22, 31'd1);
		add_job(31'd30, 31'd0);
		timeline = 30;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: count = 5'd16;
				1: count = 5'd1;
				2: count = 5'd5;
				3: count = 5'd31;
				6: count = 5'd0;
				7: count = 5'd16;
				default: count = lfsa_pkg::SRV_NUM_W'($urandom_range(0, 31));
			endcase
			cnt_eff = (count == 0) ? 1 : (int'(count) > SERVERS) ? SERVERS : int'(count);
			dur_max = (p == 7) ? 32'h0FFF_FFFF : $urandom_range(20, 3000);
			if (p == 7)
				timeline = 64'h7FF0_0000;
			begin_phase(count, p % 4);
			// fill the block while the receiver holds off
			if (p == 4)
				hold_req = ~hold_req;
			queue_jobs(80, dur_max, dur_max * $urandom_range(1, 4) / (2 * cnt_eff) + 1);
		end

		// field extremes, alternating bit patterns and finish saturation
		begin_phase(5'd16, 0);
		add_job(TIME_MAX, TIME_MAX);
		add_job(31'h2AAA_AAAA, 31'h5555_5555);
		add_job(31'h5555_5555, 31'h2AAA_AAAA);
		begin_phase(5'd1, 2);
		add_job(TIME_MAX, TIME_MAX);
		add_job(TIME_MAX, TIME_MAX);
		add_job(TIME_MAX, 31'd0);

		wait_idle();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
